@@ sv/tpqm_pkg.sv @@
// Shared types, constants and widths for the timecode pulse quality meter.
package tpqm_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned MdevW  = 7;
  localparam int unsigned DevW   = 8;
  localparam int unsigned LagW   = 7;
  localparam int unsigned QualW  = 7;
  localparam int unsigned NumW   = 15;
  localparam int unsigned DenW   = 8;
  localparam int unsigned QuoW   = 7;
  localparam int unsigned CntW   = 3;
  localparam int unsigned SnapW  = 11;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 24;

  localparam logic [MdevW-1:0] MaxDevReset = 7'd50;
  localparam logic [LagW-1:0]  LagReset    = 7'd50;
  localparam logic [MdevW-1:0] NoiseBase   = 7'd100;
  localparam logic [QualW-1:0] FullQuality = 7'd100;

  // Snap points and midpoints in milliseconds
  localparam logic [SnapW-1:0] ShortPulse = 11'd100;
  localparam logic [SnapW-1:0] LongPulse  = 11'd200;
  localparam logic [SnapW-1:0] GapAfterOne  = 11'd800;
  localparam logic [SnapW-1:0] GapAfterZero = 11'd900;
  localparam logic [SnapW-1:0] MinuteExtra  = 11'd1000;
  localparam logic [SnapW-1:0] PulseMid     = 11'd150;
  localparam logic [SnapW-1:0] GapMidOne    = 11'd1300;
  localparam logic [SnapW-1:0] GapMidZero   = 11'd1400;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEN,
    ST_CLASS,
    ST_DEV,
    ST_QSET,
    ST_DIV,
    ST_DONE
  } ctrl_state_e;

  // Strobes from the sequencer to the datapath
  typedef struct packed {
    logic accept;
    logic load_len;
    logic classify;
    logic calc_dev;
    logic q_start;
    logic out_load;
  } ctl_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic edge_seen;
    logic have_edge;
    logic md_zero;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

@@ sv/timecode_pulse_quality_meter.sv @@
// Top level of the timecode pulse quality meter: datapath, sequencer and divider.
//
// Usage: each slave-side transaction carries one receiver sample (level and
// a free-running millisecond time). For every sample the block returns
// exactly one master-side transaction with the measurement result, the
// last decoded bit, the minute-start flag and a quality percentage.
// The max_deviation register is written over the cfg channel, which is
// always ready; write it only while the block is idle.
//
// Sequence: a sample whose level closes a measured pulse runs length,
// classify, deviation, setup and a serial divide; samples without a
// measured edge skip two steps. With max_deviation zero the divide is
// skipped. One sample is in work at a time, so the slave side takes a
// new transaction only once the result has gone to the output register.
//
// Reset: max_deviation returns to 50, both lags to 50, the edge history
// is cleared, and both sides come up idle. If the receiver stalls, the
// finished result waits in the output register and the sequencer holds in
// its last step until the output register frees.
module timecode_pulse_quality_meter (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // tdata: level [0], now_ms [32:1], zero fill [39:33]
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [tpqm_pkg::InDataW-1:0]       s_axis_tdata_i,
  // tdata: edge_measured [0], deviation [8:1], data_bit [9],
  //        minute_start [10], quality [17:11], zero fill [23:18]
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [tpqm_pkg::OutDataW-1:0]      m_axis_tdata_o,
  // max_deviation register write
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [tpqm_pkg::MdevW-1:0]         cfg_data_i
);
  import tpqm_pkg::*;

  ctl_t ctl;
  sts_t sts;

  logic [MdevW-1:0] md_q;
  logic             prev_lvl_q;
  logic [TimeW-1:0] last_time_q;
  logic             have_edge_q;
  logic             dbit_q;
  logic [LagW-1:0]  lag0_q, lag1_q;
  logic             in_lvl_q;
  logic [TimeW-1:0] in_now_q;
  logic [TimeW-1:0] len_q;
  logic             noise_q, snap_hi_q;
  logic             measured_q, minute_q;
  logic [DevW-1:0]  dev_q;
  logic             m_valid_q;
  logic [OutDataW-1:0] m_data_q;

  logic              edge_w;
  logic [TimeW:0]    sub_a, sub_b, sub_y;
  logic [MdevW-1:0]  thr_w;
  logic [SnapW-1:0]  mid_w, expect_w;
  logic [DevW-1:0]   dev_sat;
  logic [LagW-1:0]   dev_abs;
  logic [LagW-1:0]   l0c, l1c;
  logic [LagW:0]     lag_sum;
  logic [NumW-1:0]   num_w;
  logic [DenW-1:0]   den_w;
  logic              div_busy, div_done;
  logic [QuoW-1:0]   quo;
  logic [QualW-1:0]  quality_w;

  assign edge_w = in_lvl_q != prev_lvl_q;

  // Shared subtractor: pulse length first, deviation later
  always_comb begin
    if (ctl.load_len) begin
      sub_a = {1'b0, in_now_q};
      sub_b = {1'b0, last_time_q};
    end else begin
      sub_a = {1'b0, len_q};
      sub_b = {{(TimeW + 1 - SnapW){1'b0}}, expect_w};
    end
  end
  assign sub_y = sub_a - sub_b;

  // Noise threshold and snap midpoint
  assign thr_w = (md_q > NoiseBase) ? '0 : NoiseBase - md_q;
  always_comb begin
    if (!in_lvl_q)   mid_w = PulseMid;
    else if (dbit_q) mid_w = GapMidOne;
    else             mid_w = GapMidZero;
  end

  // Snapped expected length
  always_comb begin
    if (!in_lvl_q) begin
      expect_w = snap_hi_q ? LongPulse : ShortPulse;
    end else begin
      expect_w = (dbit_q ? GapAfterOne : GapAfterZero) + (snap_hi_q ? MinuteExtra : '0);
    end
  end

  // Saturate the deviation to +-127, noise reports max_deviation
  always_comb begin
    if (noise_q) begin
      dev_sat = {1'b0, md_q};
    end else if ($signed(sub_y) > $signed((TimeW + 1)'(127))) begin
      dev_sat = 8'sd127;
    end else if ($signed(sub_y) < -$signed((TimeW + 1)'(127))) begin
      dev_sat = -8'sd127;
    end else begin
      dev_sat = sub_y[DevW-1:0];
    end
  end
  assign dev_abs = dev_sat[DevW-1] ? LagW'(-dev_sat) : dev_sat[LagW-1:0];

  // Quality numerator and denominator
  assign l0c     = (lag0_q > md_q) ? md_q : lag0_q;
  assign l1c     = (lag1_q > md_q) ? md_q : lag1_q;
  assign lag_sum = {1'b0, l0c} + {1'b0, l1c};
  assign num_w   = {1'b0, lag_sum, 6'b0} + {2'b0, lag_sum, 5'b0} + {5'b0, lag_sum, 2'b0};
  assign den_w   = {md_q, 1'b0};
  assign quality_w = sts.md_zero ? FullQuality : FullQuality - quo;

  assign sts.edge_seen = edge_w;
  assign sts.have_edge = have_edge_q;
  assign sts.md_zero   = (md_q == '0);
  assign sts.div_done  = div_done;
  assign sts.out_free  = !m_valid_q || m_axis_tready_i;

  tpqm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .sts_i      (sts),
    .in_ready_o (s_axis_tready_o),
    .ctl_o      (ctl)
  );

  tpqm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctl.q_start),
    .dividend_i (num_w),
    .divisor_i  (den_w),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // Architectural state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      md_q        <= MaxDevReset;
      prev_lvl_q  <= 1'b0;
      last_time_q <= '0;
      have_edge_q <= 1'b0;
      dbit_q      <= 1'b0;
      lag0_q      <= LagReset;
      lag1_q      <= LagReset;
      m_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        md_q <= cfg_data_i;
      end
      if (ctl.load_len && edge_w) begin
        have_edge_q <= 1'b1;
        prev_lvl_q  <= in_lvl_q;
        last_time_q <= in_now_q;
      end
      if (ctl.calc_dev) begin
        lag1_q <= lag0_q;
        lag0_q <= dev_abs;
        if (!noise_q && !in_lvl_q) begin
          dbit_q <= snap_hi_q;
        end
      end
      if (ctl.out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Per-item working registers and result register
  always_ff @(posedge clk_i) begin
    if (ctl.accept) begin
      in_lvl_q   <= s_axis_tdata_i[0];
      in_now_q   <= s_axis_tdata_i[TimeW:1];
      measured_q <= 1'b0;
      minute_q   <= 1'b0;
      dev_q      <= '0;
    end
    if (ctl.load_len) begin
      len_q <= sub_y[TimeW-1:0];
    end
    if (ctl.classify) begin
      noise_q    <= len_q < {{(TimeW - MdevW){1'b0}}, thr_w};
      snap_hi_q  <= len_q >= {{(TimeW - SnapW){1'b0}}, mid_w};
      measured_q <= 1'b1;
    end
    if (ctl.calc_dev) begin
      dev_q <= dev_sat;
      if (!noise_q && in_lvl_q) begin
        minute_q <= snap_hi_q;
      end
    end
    if (ctl.out_load) begin
      m_data_q <= {6'b0, quality_w, minute_q, dbit_q, dev_q, measured_q};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign cfg_ready_o     = 1'b1;

  // The divider is never busy while a new sample can enter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !div_busy)
    else $error("divider busy while input ready");

  // Quality never exceeds one hundred percent
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[17:11] <= FullQuality))
    else $error("quality out of range");

  // An unmeasured result carries zero deviation and no minute start
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tdata_o[0]) |->
      (m_axis_tdata_o[8:1] == '0 && !m_axis_tdata_o[10]))
    else $error("unmeasured result carries a measurement");

  // A result is loaded only when the output register is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.out_load |-> (!m_valid_q || m_axis_tready_i))
    else $error("result overwritten before transfer");

endmodule

@@ sv/tpqm_div.sv @@
// Serial restoring divider, one quotient bit per cycle.
module tpqm_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [tpqm_pkg::NumW-1:0]     dividend_i,
  input  logic [tpqm_pkg::DenW-1:0]     divisor_i,
  output logic                          busy_o,
  output logic                          done_o,
  output logic [tpqm_pkg::QuoW-1:0]     quotient_o
);
  import tpqm_pkg::*;

  logic            busy_q, busy_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DenW-1:0] rem_q, rem_d;
  logic [QuoW-1:0] sh_q, sh_d;
  logic [DenW-1:0] den_q, den_d;
  logic [DenW:0]   trial;
  logic            last_step;

  // Trial subtract of the divisor from the shifted remainder
  assign trial     = {rem_q, sh_q[QuoW-1]} - {1'b0, den_q};
  assign last_step = busy_q && (cnt_q == CntW'(QuoW - 1));

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    sh_d   = sh_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = dividend_i[NumW-1:QuoW];
      sh_d   = dividend_i[QuoW-1:0];
      den_d  = divisor_i;
    end else if (busy_q) begin
      if (!trial[DenW]) begin
        rem_d = trial[DenW-1:0];
      end else begin
        rem_d = {rem_q[DenW-2:0], sh_q[QuoW-1]};
      end
      sh_d  = {sh_q[QuoW-2:0], ~trial[DenW]};
      cnt_d = cnt_q + 1'b1;
      if (last_step) begin
        busy_d = 1'b0;
      end
    end
  end

  // Hold control state under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
    den_q <= den_d;
  end

  assign busy_o     = busy_q;
  assign done_o     = last_step;
  assign quotient_o = sh_q;

endmodule

@@ sv/tpqm_ctrl.sv @@
// Sequencer that steps one item through measure, classify, deviation, divide setup, divide and output load.
module tpqm_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  tpqm_pkg::sts_t  sts_i,
  output logic            in_ready_o,
  output tpqm_pkg::ctl_t  ctl_o
);
  import tpqm_pkg::*;

  ctrl_state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_LEN;
      ST_LEN: begin
        if (sts_i.edge_seen && sts_i.have_edge) state_d = ST_CLASS;
        else                                   state_d = ST_QSET;
      end
      ST_CLASS: state_d = ST_DEV;
      ST_DEV:   state_d = ST_QSET;
      ST_QSET: begin
        if (sts_i.md_zero) state_d = ST_DONE;
        else               state_d = ST_DIV;
      end
      ST_DIV:   if (sts_i.div_done) state_d = ST_DONE;
      ST_DONE:  if (sts_i.out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Strobes
  always_comb begin
    ctl_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        ctl_o.accept = in_valid_i;
      end
      ST_LEN:   ctl_o.load_len = 1'b1;
      ST_CLASS: ctl_o.classify = 1'b1;
      ST_DEV:   ctl_o.calc_dev = 1'b1;
      ST_QSET:  ctl_o.q_start  = ~sts_i.md_zero;
      ST_DIV:   ;
      ST_DONE:  ctl_o.out_load = sts_i.out_free;
      default:  ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ tb/sv/tpqm_meter_check.sv @@
// Result checker for the timecode pulse quality meter: predicts each result and compares it.
module tpqm_meter_check (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_valid_i,
  input  logic                          s_ready_i,
  // level [0], now_ms [32:1], zero fill [39:33]
  input  logic [tpqm_pkg::InDataW-1:0]  s_data_i,
  input  logic                          m_valid_i,
  input  logic                          m_ready_i,
  // edge_measured [0], deviation [8:1], data_bit [9], minute_start [10],
  // quality [17:11], zero fill [23:18]
  input  logic [tpqm_pkg::OutDataW-1:0] m_data_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [tpqm_pkg::MdevW-1:0]    cfg_data_i,
  output int                            fail_count_o,
  output int                            pending_o
);
  import tpqm_pkg::*;

  localparam int MaxReported = 10;
  localparam longint DevClip = 127;

  // One result transaction, first field in the highest bits
  typedef struct packed {
    logic [5:0]        fill;
    logic [QualW-1:0]  quality;
    logic              minute_start;
    logic              data_bit;
    logic signed [7:0] deviation;
    logic              edge_measured;
  } meter_result_t;

  // Mirror of the block state
  logic [MdevW-1:0] max_dev;
  logic             prev_level;
  logic [TimeW-1:0] last_edge;
  logic             have_edge;
  logic             dec_bit;
  logic [LagW-1:0]  lag_new;
  logic [LagW-1:0]  lag_old;

  meter_result_t expected_results[$];
  meter_result_t want;
  meter_result_t got;

  // Snap a length to the nearer of two candidates; a tie goes to the larger
  function automatic longint snap_length(longint len, longint lo, longint hi);
    longint d_lo;
    longint d_hi;
    d_lo = (len > lo) ? len - lo : lo - len;
    d_hi = (len > hi) ? len - hi : hi - len;
    return (d_lo < d_hi) ? lo : hi;
  endfunction

  // Quality percent from the two stored lags
  function automatic int quality_percent();
    int md;
    int l0;
    int l1;
    int full;
    md   = int'(max_dev);
    l0   = int'(lag_new);
    l1   = int'(lag_old);
    full = int'(FullQuality);
    if (md == 0) return full;
    if (l0 > md) l0 = md;
    if (l1 > md) l1 = md;
    return full - ((l0 + l1) * full) / (2 * md);
  endfunction

  // Advance the mirrored state by one sample and form the expected result
  function automatic meter_result_t measure_sample(logic lvl, logic [TimeW-1:0] now);
    meter_result_t r;
    logic [TimeW-1:0] span;
    longint len;
    longint thr;
    longint md;
    longint target;
    longint base;
    longint dev;
    longint lo_snap;
    longint hi_snap;
    longint extra;
    r   = '0;
    dev = 0;
    md  = longint'(max_dev);
    if (lvl != prev_level) begin
      if (have_edge) begin
        span = now - last_edge;
        len  = longint'(span);
        thr  = (md > 100) ? 0 : 100 - md;
        r.edge_measured = 1'b1;
        if (len < thr) begin
          dev = md;
        end else if (lvl == 1'b0) begin
          lo_snap = ShortPulse;
          hi_snap = LongPulse;
          target  = snap_length(len, lo_snap, hi_snap);
          dec_bit = (target == hi_snap);
          dev     = len - target;
        end else begin
          base    = dec_bit ? GapAfterOne : GapAfterZero;
          extra   = MinuteExtra;
          target  = snap_length(len, base, base + extra);
          r.minute_start = (target > extra);
          dev     = len - target;
        end
        if (dev > DevClip) dev = DevClip;
        if (dev < -DevClip) dev = -DevClip;
        lag_old = lag_new;
        lag_new = LagW'((dev < 0) ? -dev : dev);
      end
      have_edge  = 1'b1;
      prev_level = lvl;
      last_edge  = now;
    end
    r.deviation = dev[7:0];
    r.data_bit  = dec_bit;
    r.quality   = QualW'(quality_percent());
    return r;
  endfunction

  // Count a failure and report the first few
  task automatic flag_mismatch(string what, longint exp_val, longint act_val);
    if (fail_count_o < MaxReported) begin
      $display("%0t: mismatch in %s: expected %0d, actual %0d", $realtime, what,
               exp_val, act_val);
    end
    fail_count_o = fail_count_o + 1;
  endtask

  // Track config writes, queue predictions, compare results in order
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_dev      = MaxDevReset;
      prev_level   = 1'b0;
      last_edge    = '0;
      have_edge    = 1'b0;
      dec_bit      = 1'b0;
      lag_new      = LagReset;
      lag_old      = LagReset;
      expected_results.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        max_dev = cfg_data_i;
      end
      if (s_valid_i && s_ready_i) begin
        expected_results.push_back(measure_sample(s_data_i[0], s_data_i[TimeW:1]));
      end
      if (m_valid_i && m_ready_i) begin
        got = m_data_i;
        if (expected_results.size() == 0) begin
          flag_mismatch("result with nothing pending (raw tdata)", 0, m_data_i);
        end else begin
          want = expected_results.pop_front();
          if (got.edge_measured !== want.edge_measured)
            flag_mismatch("edge_measured", want.edge_measured, got.edge_measured);
          if (got.deviation !== want.deviation)
            flag_mismatch("deviation", want.deviation, got.deviation);
          if (got.data_bit !== want.data_bit)
            flag_mismatch("data_bit", want.data_bit, got.data_bit);
          if (got.minute_start !== want.minute_start)
            flag_mismatch("minute_start", want.minute_start, got.minute_start);
          if (got.quality !== want.quality)
            flag_mismatch("quality", want.quality, got.quality);
          if (got.fill !== want.fill)
            flag_mismatch("tdata zero fill", want.fill, got.fill);
        end
      end
      pending_o = expected_results.size();
    end
  end

endmodule

@@ tb/sv/tb_timecode_pulse_quality_meter.sv @@
// Testbench top for the timecode pulse quality meter: stimulus, clocking and verdict.
module tb_timecode_pulse_quality_meter;
  import tpqm_pkg::*;

  localparam int RandomItems = 1850;
  localparam int StallLimit  = 5000;
  localparam int HoldCycles  = 400;
  localparam int SettleWait  = 30;

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                s_valid   = 1'b0;
  logic                s_ready;
  logic [InDataW-1:0]  s_data    = '0;
  logic                m_valid;
  logic                m_ready   = 1'b0;
  logic [OutDataW-1:0] m_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [MdevW-1:0]    cfg_data  = '0;

  int fail_count;
  int pending;

  // Stimulus shaping shared between processes
  int               tx_idle_pct = 36;
  int               rx_idle_pct = 68;
  bit               hold_req    = 1'b0;
  int               sent_items  = 0;
  int               idle_cycles = 0;
  logic [MdevW-1:0] cur_md      = MaxDevReset;
  logic [TimeW-1:0] edge_t      = '0;
  logic             tb_level    = 1'b0;

  always #5 clk_i = ~clk_i;

  timecode_pulse_quality_meter u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data)
  );

  tpqm_meter_check u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_valid),
    .s_ready_i    (s_ready),
    .s_data_i     (s_data),
    .m_valid_i    (m_valid),
    .m_ready_i    (m_ready),
    .m_data_i     (m_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Drop the run when no transaction moves for too long
  always @(posedge clk_i) begin
    if (rst_ni && !((s_valid && s_ready) || (m_valid && m_ready) ||
                    (cfg_valid && cfg_ready))) begin
      idle_cycles = idle_cycles + 1;
    end else begin
      idle_cycles = 0;
    end
    if (idle_cycles >= StallLimit) begin
      $display("tb_timecode_pulse_quality_meter: FAIL");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
        @(posedge clk_i);
      end
    end
  end

  // Offer one sample and hold it until accepted
  task automatic send_sample(logic lvl, logic [TimeW-1:0] t);
    if (lvl != tb_level) begin
      tb_level = lvl;
      edge_t   = t;
    end
    while ($urandom_range(99) < tx_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {{(InDataW - TimeW - 1){1'b0}}, t, lvl};
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    sent_items = sent_items + 1;
  endtask

  // Stop offering, then wait until every result is back and the block has settled
  task automatic wait_drain();
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleWait) @(posedge clk_i);
  endtask

  task automatic write_max_dev(logic [MdevW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    cur_md = value;
  endtask

  function automatic int jitter(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  // One well-formed second: pulse, then gap, with random timing error
  task automatic send_second();
    int   pulse;
    int   gap;
    int   span;
    logic one_bit;
    logic marker;
    if (tb_level != 1'b1) send_sample(1'b1, edge_t + $urandom_range(700, 1000));
    span    = (cur_md > 45) ? 45 : cur_md;
    one_bit = 1'($urandom_range(1));
    marker  = ($urandom_range(14) == 0);
    if ($urandom_range(24) == 0) pulse = 150;
    else pulse = (one_bit ? 200 : 100) + jitter(span);
    one_bit = (pulse >= 150);
    if ($urandom_range(3) == 0) send_sample(1'b1, edge_t + $urandom_range(pulse));
    send_sample(1'b0, edge_t + pulse);
    if ($urandom_range(24) == 0) gap = one_bit ? 1300 : 1400;
    else gap = (one_bit ? 800 : 900) + (marker ? 1000 : 0) + jitter(cur_md);
    if ($urandom_range(3) == 0) send_sample(1'b0, edge_t + $urandom_range(gap));
    send_sample(1'b1, edge_t + gap);
  endtask

  // Short spike: flip the level and flip back shortly after
  task automatic send_glitch();
    send_sample(~tb_level, edge_t + $urandom_range(50, 900));
    send_sample(~tb_level, edge_t + $urandom_range(70));
  endtask

  // Arbitrary sample, sometimes at a fully random time
  task automatic send_noise();
    if ($urandom_range(3) == 0) send_sample(1'($urandom_range(1)), $urandom);
    else send_sample(1'($urandom_range(1)), edge_t + $urandom_range(3000));
  endtask

  // Reset-state corner cases: first edge, ties, noise, saturation, wrap
  task automatic run_directed();
    logic [TimeW-1:0] t;
    send_sample(1'b0, '0);
    send_sample(1'b1, 32'hFFFF_FF00);
    send_sample(1'b1, 32'hFFFF_FFF0);
    t = 32'hFFFF_FF00 + 150;
    send_sample(1'b0, t);
    t = t + 1300;
    send_sample(1'b1, t);
    t = t + 100;
    send_sample(1'b0, t);
    t = t + 900;
    send_sample(1'b1, t);
    t = t + 10;
    send_sample(1'b0, t);
    t = t + 49;
    send_sample(1'b1, t);
    t = t + 50;
    send_sample(1'b0, t);
    t = t + 1400;
    send_sample(1'b1, t);
    t = t + 200;
    send_sample(1'b0, t);
    t = t + 1800;
    send_sample(1'b1, t);
    t = t + 327;
    send_sample(1'b0, t);
    t = t + 32'hFFFF_FFFF;
    send_sample(1'b1, t);
    send_sample(1'b1, 32'hFFFF_FFFF);
    send_sample(1'b0, '0);
    send_sample(1'b1, 32'h5555_5555);
    send_sample(1'b0, 32'hAAAA_AAAA);
  endtask

  // Main sequence: reset, directed samples, then one random phase per setting
  initial begin
    logic [MdevW-1:0] md_plan [7];
    int per_phase;
    int phase_start;
    int done_items;
    int pick;
    md_plan   = '{7'd1, 7'd99, 7'd0, 7'd127, 7'd50, 7'd100, 7'd50};
    md_plan[4] = MdevW'($urandom_range(2, 98));
    per_phase = RandomItems / 7;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    for (int ph = 0; ph < 7; ph++) begin
      wait_drain();
      write_max_dev(md_plan[ph]);
      phase_start = sent_items;
      if (ph == 0) hold_req = 1'b1;
      while (sent_items - phase_start < per_phase) begin
        // Pick the idle pattern by progress through the random part
        done_items = ph * per_phase + (sent_items - phase_start);
        if (done_items < RandomItems / 3) begin
          tx_idle_pct = 36;
          rx_idle_pct = 68;
        end else if (done_items < 2 * RandomItems / 3) begin
          tx_idle_pct = 68;
          rx_idle_pct = 36;
        end else begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
        pick = $urandom_range(99);
        if (pick < 75) send_second();
        else if (pick < 88) send_glitch();
        else send_noise();
      end
    end
    wait_drain();
    if (fail_count == 0 && pending == 0) begin
      $display("tb_timecode_pulse_quality_meter: PASS");
    end else begin
      $display("tb_timecode_pulse_quality_meter: FAIL");
    end
    $finish;
  end

endmodule
